FILE: rtl/rss_pkg.sv
// Shared types and constants for the rotated sorted search block.
// No dependencies; the other files that use this package refer to it by scoped names.
package rss_pkg;

    // Fixed field widths
    localparam int LEN_W  = 11;  // array_length register
    localparam int POS_W  = 10;  // position result / write_index field
    localparam int IDX_W  = 12;  // signed search bounds (-1 .. 2047)
    localparam int ITEM_W = 32;  // item_value field

    localparam logic signed [IDX_W-1:0] IDX_ONE = 1;

    // Request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Configuration register index (paddr[2])
    localparam logic CFG_IDX_ARRAY_LENGTH = 1'b0;

    // Search sequencer states
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_PROBE  = 5'b00010,
        ST_FETCH  = 5'b00100,
        ST_EVAL   = 5'b01000,
        ST_RESULT = 5'b10000
    } rss_state_t;

    // Result transaction payload
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } rss_result_t;

endpackage

FILE: rtl/rss_ram.sv
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module rss_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr_a,
    output logic [WIDTH-1:0]  rd_data_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read ports
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: rtl/rss_engine.sv
// Search sequencer: element store writes, binary search over the store
// and the output register. Depends on rss_pkg and rss_ram.
module rss_engine #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [rss_pkg::POS_W-1:0]       write_index,
    input  logic signed [rss_pkg::ITEM_W-1:0] item_value,
    input  logic [rss_pkg::LEN_W-1:0]       array_length,
    output logic                            out_valid,
    input  logic                            out_stall,
    output rss_pkg::rss_result_t            result
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = rss_pkg::IDX_W;

    rss_pkg::rss_state_t state_reg, state_next;

    logic signed [IDX_W-1:0]       lo_reg, lo_next;
    logic signed [IDX_W-1:0]       hi_reg, hi_next;
    logic signed [IDX_W-1:0]       mid_reg, mid_next;
    logic signed [VALUE_WIDTH-1:0] target_reg, target_next;
    logic signed [VALUE_WIDTH-1:0] m_reg, m_next;
    logic signed [VALUE_WIDTH-1:0] z_reg, z_next;
    logic                          found_reg, found_next;
    logic [rss_pkg::POS_W-1:0]     pos_reg, pos_next;
    logic                          out_valid_reg, out_valid_next;
    rss_pkg::rss_result_t          out_res_reg, out_res_next;

    logic signed [VALUE_WIDTH-1:0] key;
    logic signed [IDX_W-1:0]       mid_calc;
    logic signed [VALUE_WIDTH-1:0] a_val;
    logic                          wr_en;
    logic [ADDR_W-1:0]             wr_addr;
    logic [ADDR_W-1:0]             rd_addr_a;
    logic [ADDR_W-1:0]             rd_addr_b;
    logic [VALUE_WIDTH-1:0]        rd_data_a;
    logic [VALUE_WIDTH-1:0]        rd_data_b;
    logic                          out_free;

    // Value as held in the store: truncated or sign-extended to VALUE_WIDTH
    assign key = VALUE_WIDTH'(item_value);

    // Element store
    rss_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (key),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // Writes land in the idle cycle they are accepted; out-of-range indices dropped
    assign wr_en   = (state_reg == rss_pkg::ST_IDLE) && in_valid
                     && (req_type == rss_pkg::REQ_WRITE)
                     && (32'(write_index) < DEPTH);
    assign wr_addr = ADDR_W'(write_index);

    assign in_stall  = (state_reg != rss_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = out_res_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Midpoint of the current range (bounds are non-negative when used)
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >>> 1);
    assign a_val    = signed'(rd_data_a);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        target_next    = target_reg;
        m_next         = m_reg;
        z_next         = z_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        rd_addr_a      = ADDR_W'(mid_calc[IDX_W-2:0]);
        rd_addr_b      = ADDR_W'(hi_reg[IDX_W-2:0]);

        // Result taken by the downstream side
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            rss_pkg::ST_IDLE:
            begin
                if (in_valid && (req_type == rss_pkg::REQ_SEARCH))
                begin
                    target_next = key;
                    lo_next     = '0;
                    hi_next     = signed'({1'b0, array_length}) - rss_pkg::IDX_ONE;
                    state_next  = rss_pkg::ST_PROBE;
                end
            end

            // Range check, then read middle and upper elements
            rss_pkg::ST_PROBE:
            begin
                if (lo_reg > hi_reg)
                begin
                    found_next = 1'b0;
                    pos_next   = '0;
                    state_next = rss_pkg::ST_RESULT;
                end
                else
                begin
                    mid_next   = mid_calc;
                    state_next = rss_pkg::ST_FETCH;
                end
            end

            // Capture middle/upper elements, read the lower element
            rss_pkg::ST_FETCH:
            begin
                m_next     = signed'(rd_data_a);
                z_next     = signed'(rd_data_b);
                rd_addr_a  = ADDR_W'(lo_reg[IDX_W-2:0]);
                state_next = rss_pkg::ST_EVAL;
            end

            // Narrow the range
            rss_pkg::ST_EVAL:
            begin
                state_next = rss_pkg::ST_PROBE;
                if (m_reg == target_reg)
                begin
                    found_next = 1'b1;
                    pos_next   = mid_reg[rss_pkg::POS_W-1:0];
                    state_next = rss_pkg::ST_RESULT;
                end
                else if (m_reg > z_reg)
                begin
                    // left half ordered
                    if ((target_reg >= a_val) && (target_reg <= m_reg))
                    begin
                        hi_next = mid_reg;
                    end
                    else
                    begin
                        lo_next = mid_reg + rss_pkg::IDX_ONE;
                    end
                end
                else if (m_reg < z_reg)
                begin
                    // right half ordered
                    if ((target_reg >= m_reg) && (target_reg <= z_reg))
                    begin
                        lo_next = (mid_reg == lo_reg) ? mid_reg + rss_pkg::IDX_ONE : mid_reg;
                    end
                    else
                    begin
                        hi_next = mid_reg - rss_pkg::IDX_ONE;
                    end
                end
                else
                begin
                    // duplicate at the upper end
                    hi_next = hi_reg - rss_pkg::IDX_ONE;
                end
            end

            // Hand the result to the output register once it is free
            rss_pkg::ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    out_res_next.found    = found_reg;
                    out_res_next.position = pos_reg;
                    state_next            = rss_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rss_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rss_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        target_reg  <= target_next;
        m_reg       <= m_next;
        z_reg       <= z_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
        out_res_reg <= out_res_next;
    end

endmodule

FILE: rtl/rotated_sorted_search_top.sv
// Search of a rotated sorted array: a write is accepted while idle and gives no result.
// A search runs probes (middle/upper read, lower read, compare): about
// log2(n)+1 probes for distinct values, up to n when duplicates shrink the range by one.
// The result is registered as the sequencer returns to idle, so the next transaction
// can be taken even while that result waits.
// Reset clears sequencer, output valid and array_length, not the store. Uses rss_engine.
module rotated_sorted_search_top #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // request channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [rss_pkg::POS_W-1:0]         write_index,
    input  logic signed [rss_pkg::ITEM_W-1:0] item_value,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              found,
    output logic [rss_pkg::POS_W-1:0]         position
);

    logic [rss_pkg::LEN_W-1:0] array_length_reg, array_length_next;
    logic [rss_pkg::LEN_W-1:0] wr_len;
    logic                      cfg_wr;
    rss_pkg::rss_result_t      result;

    // APB register: array_length, clamped to the store depth
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2] == rss_pkg::CFG_IDX_ARRAY_LENGTH);
    assign wr_len = (32'(pwdata[rss_pkg::LEN_W-1:0]) > DEPTH)
                    ? rss_pkg::LEN_W'(DEPTH) : pwdata[rss_pkg::LEN_W-1:0];
    assign array_length_next = cfg_wr ? wr_len : array_length_reg;
    assign prdata = (paddr[2] == rss_pkg::CFG_IDX_ARRAY_LENGTH)
                    ? 32'(array_length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            array_length_reg <= '0;
        end
        else
        begin
            array_length_reg <= array_length_next;
        end
    end

    // Search engine
    rss_engine #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .write_index  (write_index),
        .item_value   (item_value),
        .array_length (array_length_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result       (result)
    );

    assign found    = result.found;
    assign position = result.position;

`ifndef SYNTHESIS
    // A miss always reports position zero
    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (position == '0))
        else $error("not-found result with non-zero position");

    // Stored length never exceeds the store depth
    a_len_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        32'(array_length_reg) <= DEPTH)
        else $error("array_length above depth");

    // An accepted search keeps the request side stalled the next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (req_type == rss_pkg::REQ_SEARCH)) |=> in_stall)
        else $error("search accepted but engine not busy");

    // A write never stalls the request side
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (req_type == rss_pkg::REQ_WRITE)) |=> !in_stall)
        else $error("write left the engine busy");
`endif

endmodule

FILE: bench/rotated_sorted_search_top_tb.sv
// Self-checking testbench for rotated_sorted_search_top: element writes and searches,
// each search result checked against an in-bench model of the modified binary search.
// Depends on rss_pkg and the RTL of rotated_sorted_search_top.
module rotated_sorted_search_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_DEPTH   = 1024;
    localparam int MAX_BURST     = 19;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 400;
    localparam int LONG_LENGTH   = 160;

    // Register addresses: index in paddr[2], byte aligned
    localparam logic [2:0] ADDR_ARRAY_LENGTH = {rss_pkg::CFG_IDX_ARRAY_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_SPARE        = {~rss_pkg::CFG_IDX_ARRAY_LENGTH, 2'b00};

    localparam logic signed [rss_pkg::ITEM_W-1:0] VALUE_MIN =
        {1'b1, {(rss_pkg::ITEM_W-1){1'b0}}};
    localparam logic signed [rss_pkg::ITEM_W-1:0] VALUE_MAX =
        {1'b0, {(rss_pkg::ITEM_W-1){1'b1}}};

    typedef struct {
        logic                              kind;
        logic [rss_pkg::POS_W-1:0]         index;
        logic signed [rss_pkg::ITEM_W-1:0] value;
    } request_t;

    // DUT signals; the ones the bench drives are known from time zero
    logic                              clk         = 1'b0;
    logic                              rst_n       = 1'b0;
    logic                              psel        = 1'b0;
    logic                              penable     = 1'b0;
    logic                              pwrite      = 1'b0;
    logic [2:0]                        paddr       = '0;
    logic [31:0]                       pwdata      = '0;
    logic [31:0]                       prdata;
    logic                              pready;
    logic                              in_valid    = 1'b0;
    logic                              in_stall;
    logic                              req_type    = rss_pkg::REQ_WRITE;
    logic [rss_pkg::POS_W-1:0]         write_index = '0;
    logic signed [rss_pkg::ITEM_W-1:0] item_value  = '0;
    logic                              out_valid;
    logic                              out_stall   = 1'b0;
    logic                              found;
    logic [rss_pkg::POS_W-1:0]         position;

    // Bench state
    request_t                          pending_requests [$];
    rss_pkg::rss_result_t              expected_results [$];
    logic signed [rss_pkg::ITEM_W-1:0] store_mirror [STORE_DEPTH];
    logic [rss_pkg::LEN_W-1:0]         length_mirror = '0;
    int                                req_offered   = 0;
    int                                req_accepted  = 0;
    int                                error_count   = 0;
    int                                tx_idle_pct   = 0;
    int                                rx_idle_pct   = 0;
    int                                tx_gap_left   = 0;
    int                                rx_stall_left = 0;
    int                                hold_left     = 0;
    bit                                hold_request  = 1'b0;
    bit                                hold_taken    = 1'b0;
    longint                            cycle_count   = 0;
    longint                            cycle_budget  = 0;

    rotated_sorted_search_top #(
        .DEPTH       (STORE_DEPTH),
        .VALUE_WIDTH (rss_pkg::ITEM_W)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .write_index (write_index),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .position    (position)
    );

    // Clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // Modified binary search over the mirrored store
    function automatic rss_pkg::rss_result_t search_rotated(
        input logic signed [rss_pkg::ITEM_W-1:0] target);
        rss_pkg::rss_result_t              res;
        int                                lo;
        int                                hi;
        int                                mid;
        logic signed [rss_pkg::ITEM_W-1:0] m;
        logic signed [rss_pkg::ITEM_W-1:0] a;
        logic signed [rss_pkg::ITEM_W-1:0] z;
        res.found    = 1'b0;
        res.position = '0;
        lo = 0;
        hi = int'(length_mirror) - 1;
        while (lo <= hi)
        begin
            mid = lo + (hi - lo) / 2;
            m   = store_mirror[mid];
            a   = store_mirror[lo];
            z   = store_mirror[hi];
            if (m == target)
            begin
                res.found    = 1'b1;
                res.position = rss_pkg::POS_W'(mid);
                return res;
            end
            if (m > z)
            begin
                // left half ordered
                if (target >= a && target <= m)
                    hi = mid;
                else
                    lo = mid + 1;
            end
            else if (m < z)
            begin
                // right half ordered
                if (target >= m && target <= z)
                    lo = (mid == lo) ? mid + 1 : mid;
                else
                    hi = mid - 1;
            end
            else
                hi--;   // duplicates at the ends: shrink by one
        end
        return res;
    endfunction

    // Queue one transaction and extend the time budget by its worst case
    task automatic push_request(input logic kind, input int index,
                                input logic signed [rss_pkg::ITEM_W-1:0] value);
        request_t r;
        r.kind  = kind;
        r.index = rss_pkg::POS_W'(index);
        r.value = value;
        pending_requests.insert(pending_requests.size(), r);
        cycle_budget += 2 * MAX_BURST + 4;
        if (kind == rss_pkg::REQ_SEARCH)
            cycle_budget += 3 * int'(length_mirror) + 2;
    endtask

    // APB write: setup then access, committed when pready is high
    task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr[2] == rss_pkg::CFG_IDX_ARRAY_LENGTH)
            length_mirror = (data[rss_pkg::LEN_W-1:0] > STORE_DEPTH)
                            ? rss_pkg::LEN_W'(STORE_DEPTH) : data[rss_pkg::LEN_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cycle_budget += 8;
    endtask

    // Wait until everything sent has been answered, then let trailing writes finish
    task automatic wait_for_quiet();
        do @(negedge clk);
        while (pending_requests.size() != 0 || req_accepted != req_offered ||
               expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cycle_budget += SETTLE_CYCLES + 4;
    endtask

    function automatic logic signed [rss_pkg::ITEM_W-1:0] random_value(input bit narrow);
        int pick;
        pick = $urandom_range(19);
        if (pick == 0)
            return VALUE_MIN;
        else if (pick == 1)
            return VALUE_MAX;
        else if (narrow)
            return int'($urandom_range(40)) - 20;
        else
            return $urandom();
    endfunction

    // One phase: set the length, optionally load a rotated sorted array, then search with occasional writes
    task automatic run_search_phase(input int length, input bit fill, input bit narrow,
                                    input int searches, input bit hold);
        int vals [$];
        int order [$];
        int covered;
        int rot;
        int pick;
        write_register(ADDR_ARRAY_LENGTH, length);
        covered = int'(length_mirror);
        if (fill)
        begin
            for (int i = 0; i < covered; i++)
                vals.insert(vals.size(), random_value(narrow));
            vals.sort();
            for (int i = 1; i < covered; i++)
                if ($urandom_range(99) < 25)
                    vals[i] = vals[i-1];
            rot = $urandom_range(covered - 1);
            for (int i = 0; i < covered; i++)
                order.insert(order.size(), i);
            order.shuffle();
            foreach (order[k])
                push_request(rss_pkg::REQ_WRITE, order[k],
                             vals[(order[k] + rot) % covered]);
        end
        else
        begin
            for (int i = 0; i < covered; i++)
                vals.insert(vals.size(), store_mirror[i]);
        end
        if (hold)
        begin
            // let the writes drain, then stall the results while searches pile up
            wait_for_quiet();
            tx_idle_pct  = 0;
            hold_request = 1'b1;
            cycle_budget += LONG_HOLD;
        end
        for (int s = 0; s < searches; s++)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                push_request(rss_pkg::REQ_WRITE, $urandom_range(STORE_DEPTH - 1),
                             random_value(narrow));
            else if (pick < 60)
                push_request(rss_pkg::REQ_SEARCH, 0, vals[$urandom_range(covered - 1)]);
            else if (pick < 80)
                push_request(rss_pkg::REQ_SEARCH, 0,
                             vals[$urandom_range(covered - 1)] + ($urandom_range(1) ? 1 : -1));
            else
                push_request(rss_pkg::REQ_SEARCH, 0, random_value(narrow));
        end
        wait_for_quiet();
    endtask

    // Request driver: presents queued transactions with random gaps
    always @(negedge clk)
    begin : drive_requests
        request_t next_req;
        if (!rst_n || (in_valid && req_accepted != req_offered))
        begin
            // in reset, or the offered transaction is still stalled
        end
        else if (tx_gap_left > 0)
        begin
            tx_gap_left--;
            in_valid <= 1'b0;
        end
        else if (pending_requests.size() == 0)
            in_valid <= 1'b0;
        else if ($urandom_range(99) < tx_idle_pct)
        begin
            tx_gap_left = $urandom_range(MAX_BURST - 1);
            in_valid <= 1'b0;
        end
        else
        begin
            next_req = pending_requests.pop_front();
            req_type    <= next_req.kind;
            write_index <= next_req.index;
            item_value  <= next_req.value;
            in_valid    <= 1'b1;
            req_offered++;
        end
    end

    // Result receiver: random stall bursts plus one long hold-off
    always @(negedge clk)
    begin : drive_result_stall
        if (hold_request && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            out_stall <= 1'b1;
        end
        else if ($urandom_range(99) < rx_idle_pct)
        begin
            rx_stall_left = $urandom_range(MAX_BURST - 1);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Prediction on accepted requests, checking on accepted results
    always @(posedge clk)
    begin : check_transactions
        rss_pkg::rss_result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                req_accepted++;
                if (req_type == rss_pkg::REQ_WRITE)
                    store_mirror[write_index] = item_value;
                else
                    expected_results.insert(expected_results.size(),
                                            search_rotated(item_value));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual found %0b position %0d",
                             $time, found, position);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (found !== want.found)
                    begin
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want.found, found);
                        error_count++;
                    end
                    if (position !== want.position)
                    begin
                        $display("%0t: position mismatch: expected %0d actual %0d",
                                 $time, want.position, position);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count > 4 * cycle_budget + 20000)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stimulus and end of run
    initial
    begin : stimulus
        int length;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty range straight after reset
        push_request(rss_pkg::REQ_SEARCH, 0, 0);
        wait_for_quiet();

        // Rotated array with duplicates and both value extremes
        write_register(ADDR_ARRAY_LENGTH, 8);
        push_request(rss_pkg::REQ_WRITE, 0, 5);
        push_request(rss_pkg::REQ_WRITE, 1, 7);
        push_request(rss_pkg::REQ_WRITE, 2, 7);
        push_request(rss_pkg::REQ_WRITE, 3, VALUE_MAX);
        push_request(rss_pkg::REQ_WRITE, 4, VALUE_MIN);
        push_request(rss_pkg::REQ_WRITE, 5, VALUE_MIN);
        push_request(rss_pkg::REQ_WRITE, 6, 0);
        push_request(rss_pkg::REQ_WRITE, 7, 3);
        push_request(rss_pkg::REQ_SEARCH, 0, VALUE_MIN);
        push_request(rss_pkg::REQ_SEARCH, 0, VALUE_MAX);
        push_request(rss_pkg::REQ_SEARCH, 0, 7);
        push_request(rss_pkg::REQ_SEARCH, 0, 4);
        push_request(rss_pkg::REQ_SEARCH, 0, 3);
        push_request(rss_pkg::REQ_SEARCH, 0, -1);
        wait_for_quiet();

        // Write to an unused register must leave the length alone
        write_register(ADDR_SPARE, 1);
        push_request(rss_pkg::REQ_SEARCH, 0, 0);
        wait_for_quiet();

        // Explicit zero length
        write_register(ADDR_ARRAY_LENGTH, 0);
        push_request(rss_pkg::REQ_SEARCH, 0, VALUE_MAX);
        wait_for_quiet();

        // Unsorted contents: search still ends
        write_register(ADDR_ARRAY_LENGTH, 4);
        push_request(rss_pkg::REQ_WRITE, 0, 9);
        push_request(rss_pkg::REQ_WRITE, 1, -3);
        push_request(rss_pkg::REQ_WRITE, 2, 12);
        push_request(rss_pkg::REQ_WRITE, 3, 1);
        push_request(rss_pkg::REQ_SEARCH, 0, 12);
        push_request(rss_pkg::REQ_SEARCH, 0, 1);
        wait_for_quiet();

        // Random phases, mostly short arrays
        for (int p = 0; p < 9; p++)
        begin
            tx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
            rx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(40, 5);
            if (p == 0)
                length = 1;
            else if (p == 1)
                length = 2;
            else if (p % 4 == 3)
                length = $urandom_range(200, 49);
            else
                length = $urandom_range(48, 3);
            run_search_phase(length, 1'b1, 1'($urandom_range(1)),
                             $urandom_range(45, 25), p == 2);
        end

        // Longer array, then a second pass over it with no idling at all
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        run_search_phase(LONG_LENGTH, 1'b1, 1'b0, 40, 1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_search_phase(LONG_LENGTH, 1'b0, 1'b0, 40, 1'b0);

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
